/* sv/tmgr_pkg.sv */
// Shared constants, codes and the 5x7 font for the text-mode glyph renderer.
// No dependencies; used by text_mode_glyph_renderer.
package tmgr_pkg;

  // Panel geometry (fixed)
  localparam int PANEL_WIDTH   = 128;
  localparam int PANEL_PAGES   = 8;
  localparam int STORE_BYTES   = PANEL_WIDTH * PANEL_PAGES;
  localparam int STORE_AW      = $clog2(STORE_BYTES);
  localparam int CELL_PITCH    = 6;
  localparam int GLYPH_COLS    = 5;

  // Defaults for the top-level parameters
  localparam int TEXT_LINES_DEF     = 4;
  localparam int CELLS_PER_LINE_DEF = 21;

  // Stream widths
  localparam int IN_TDATA_W  = 24;  // opcode 2 + char_code 8 + address 10, padded
  localparam int OUT_TDATA_W = 24;  // read_data 8 + status 2 + line 3 + column 5, padded

  // Opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PUT   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DRAWN   = 2'd0;
  localparam logic [1:0] ST_NEWLINE = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  typedef logic [8*GLYPH_COLS-1:0] glyph_t;  // column 0 in the low byte

  function automatic glyph_t g5(input logic [7:0] c0, input logic [7:0] c1,
                                input logic [7:0] c2, input logic [7:0] c3,
                                input logic [7:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  // Glyph lookup: lower case folded to upper, unknown codes show '?'
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [7:0] c;
    glyph_t     g;
    c = code;
    if (code >= 8'h61 && code <= 8'h7a) c = code - 8'd32;
    case (c)
      8'h41:   g = g5(8'h7e, 8'h11, 8'h11, 8'h7e, 8'h00);  // A
      8'h42:   g = g5(8'h7f, 8'h49, 8'h49, 8'h36, 8'h00);
      8'h43:   g = g5(8'h3e, 8'h41, 8'h41, 8'h22, 8'h00);
      8'h44:   g = g5(8'h7f, 8'h41, 8'h41, 8'h3e, 8'h00);
      8'h45:   g = g5(8'h7f, 8'h49, 8'h49, 8'h41, 8'h00);
      8'h46:   g = g5(8'h7f, 8'h09, 8'h09, 8'h01, 8'h00);
      8'h47:   g = g5(8'h3e, 8'h41, 8'h49, 8'h7a, 8'h00);
      8'h48:   g = g5(8'h7f, 8'h08, 8'h08, 8'h7f, 8'h00);
      8'h49:   g = g5(8'h41, 8'h7f, 8'h41, 8'h00, 8'h00);
      8'h4a:   g = g5(8'h20, 8'h40, 8'h41, 8'h3f, 8'h00);
      8'h4b:   g = g5(8'h7f, 8'h08, 8'h14, 8'h63, 8'h00);
      8'h4c:   g = g5(8'h7f, 8'h40, 8'h40, 8'h00, 8'h00);
      8'h4d:   g = g5(8'h7f, 8'h06, 8'h18, 8'h06, 8'h7f);
      8'h4e:   g = g5(8'h7f, 8'h06, 8'h18, 8'h7f, 8'h00);
      8'h4f:   g = g5(8'h3e, 8'h41, 8'h41, 8'h3e, 8'h00);
      8'h50:   g = g5(8'h7f, 8'h09, 8'h09, 8'h06, 8'h00);
      8'h51:   g = g5(8'h3e, 8'h41, 8'h61, 8'h7e, 8'h00);
      8'h52:   g = g5(8'h7f, 8'h09, 8'h19, 8'h66, 8'h00);
      8'h53:   g = g5(8'h46, 8'h49, 8'h49, 8'h31, 8'h00);
      8'h54:   g = g5(8'h01, 8'h7f, 8'h01, 8'h00, 8'h00);
      8'h55:   g = g5(8'h3f, 8'h40, 8'h40, 8'h3f, 8'h00);
      8'h56:   g = g5(8'h1f, 8'h60, 8'h60, 8'h1f, 8'h00);
      8'h57:   g = g5(8'h7f, 8'h30, 8'h0c, 8'h30, 8'h7f);
      8'h58:   g = g5(8'h63, 8'h1c, 8'h1c, 8'h63, 8'h00);
      8'h59:   g = g5(8'h07, 8'h78, 8'h07, 8'h00, 8'h00);
      8'h5a:   g = g5(8'h61, 8'h51, 8'h49, 8'h47, 8'h00);  // Z
      8'h30:   g = g5(8'h3e, 8'h41, 8'h41, 8'h3e, 8'h00);  // 0
      8'h31:   g = g5(8'h42, 8'h7f, 8'h40, 8'h00, 8'h00);
      8'h32:   g = g5(8'h62, 8'h51, 8'h49, 8'h46, 8'h00);
      8'h33:   g = g5(8'h22, 8'h49, 8'h49, 8'h36, 8'h00);
      8'h34:   g = g5(8'h18, 8'h14, 8'h12, 8'h7f, 8'h00);
      8'h35:   g = g5(8'h2f, 8'h49, 8'h49, 8'h31, 8'h00);
      8'h36:   g = g5(8'h3e, 8'h49, 8'h49, 8'h30, 8'h00);
      8'h37:   g = g5(8'h01, 8'h71, 8'h09, 8'h07, 8'h00);
      8'h38:   g = g5(8'h36, 8'h49, 8'h49, 8'h36, 8'h00);
      8'h39:   g = g5(8'h06, 8'h49, 8'h49, 8'h3e, 8'h00);  // 9
      8'h20:   g = g5(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // space
      8'h21:   g = g5(8'h00, 8'h00, 8'h5f, 8'h00, 8'h00);  // !
      8'h2e:   g = g5(8'h00, 8'h40, 8'h00, 8'h00, 8'h00);  // .
      8'h2c:   g = g5(8'h00, 8'h20, 8'h40, 8'h00, 8'h00);  // ,
      8'h2d:   g = g5(8'h08, 8'h08, 8'h08, 8'h00, 8'h00);  // -
      8'h5f:   g = g5(8'h40, 8'h40, 8'h40, 8'h40, 8'h40);  // _
      8'h2f:   g = g5(8'h60, 8'h18, 8'h06, 8'h01, 8'h00);  // /
      8'h3a:   g = g5(8'h00, 8'h36, 8'h00, 8'h00, 8'h00);  // :
      8'h2a:   g = g5(8'h04, 8'h0e, 8'h1f, 8'h0e, 8'h04);  // *
      default: g = g5(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);  // ? and unknown
    endcase
    return g;
  endfunction

endpackage

/* sv/tmgr_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tmgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

/* sv/text_mode_glyph_renderer.sv */
// Text-mode glyph renderer: draws a character stream into a 1024-byte
// page-organized frame store. Depends on tmgr_pkg and tmgr_ram.
//
//  channel | dir | ports                          | item
//  --------+-----+--------------------------------+-------------------------------------
//  in      | in  | in_tvalid/in_tready/in_tdata   | opcode, char_code, address
//  out     | out | out_tvalid/out_tready/out_tdata| read_data, status, line, column
//
// One item at a time. A drawn glyph runs accept, five byte writes into the
// single write port of the frame store, result load; a read runs accept,
// registered RAM read, result load; clear, newline, dropped and unused
// opcodes run accept, result load. The result register frees the input
// side: the next item is taken while the previous result still waits for
// out_tready. rst_n is synchronous, active low. Cursor and the per-cell
// written flags reset at once; the RAM itself is never swept. A cell that
// is not flagged reads as zero, and every glyph write covers its whole cell,
// so clear leaves the RAM alone. Bytes outside text cells always read as zero.
module text_mode_glyph_renderer #(
  parameter int TEXT_LINES     = tmgr_pkg::TEXT_LINES_DEF,      // 1..4
  parameter int CELLS_PER_LINE = tmgr_pkg::CELLS_PER_LINE_DEF   // 1..21
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [1:0] opcode, [9:2] char_code, [19:10] address, [23:20] zero
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tmgr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: [7:0] read_data, [9:8] status, [12:10] cursor_line,
  //            [17:13] cursor_column, [23:18] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tmgr_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import tmgr_pkg::*;

  localparam int NCELLS = TEXT_LINES * CELLS_PER_LINE;
  localparam int CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam logic [2:0] LINES_L = 3'(TEXT_LINES);
  localparam logic [4:0] CELLS_L = 5'(CELLS_PER_LINE);
  localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
  localparam logic [6:0] PAD_COL  = 7'(CELL_PITCH - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WRITE = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_PEND  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [2:0]        line_r, line_nxt;
  logic [4:0]        col_r, col_nxt;
  logic [NCELLS-1:0] valid_r, valid_nxt;
  logic              out_valid_r, out_valid_nxt;

  glyph_t              glyph_r, glyph_nxt;
  logic [STORE_AW-1:0] wr_addr_r, wr_addr_nxt;
  logic [2:0]          wr_cnt_r, wr_cnt_nxt;
  logic                hit_r, hit_nxt;
  logic [7:0]          res_data_r, res_data_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [1:0]          in_op;
  logic [7:0]          in_code;
  logic [STORE_AW-1:0] in_addr;
  logic                accept;

  logic [7:0]          ram_rdata;
  logic                ram_we, ram_re;

  // put decode
  logic [2:0]          p_line;
  logic [4:0]          p_col;
  logic [7:0]          p_col6;
  logic [CELL_W-1:0]   p_cell;

  // read decode
  logic [2:0]          r_page;
  logic [2:0]          r_line;
  logic [6:0]          r_col;
  logic [13:0]         r_prod;
  logic [5:0]          r_cell;
  logic [6:0]          r_rem;
  logic                r_in_text;
  logic [CELL_W-1:0]   r_idx;

  assign in_op   = in_tdata[1:0];
  assign in_code = in_tdata[9:2];
  assign in_addr = in_tdata[19:10];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // Cursor position a drawn glyph lands on (wraps a full line first).
  always_comb begin
    p_line = line_r;
    p_col  = col_r;
    if (col_r >= CELLS_L) begin
      p_line = line_r + 3'd1;
      p_col  = 5'd0;
    end
    p_col6 = ({3'b0, p_col} << 2) + ({3'b0, p_col} << 1);
    p_cell = CELL_W'(int'(p_line) * CELLS_PER_LINE + int'(p_col));
  end

  // Map a byte address to its text cell; col/6 by reciprocal 43/256.
  always_comb begin
    r_page    = in_addr[9:7];
    r_line    = {1'b0, r_page[2:1]};
    r_col     = in_addr[6:0];
    r_prod    = {7'b0, r_col} * 14'd43;
    r_cell    = r_prod[13:8];
    r_rem     = r_col - ({1'b0, r_cell} * 7'd6);
    r_in_text = !r_page[0] && (r_line < LINES_L) && ({1'b0, r_cell} < 7'(CELLS_PER_LINE))
                && (r_rem != PAD_COL);
    r_idx     = CELL_W'(int'(r_line) * CELLS_PER_LINE + int'(r_cell));
  end

  assign ram_we = (state_r == S_WRITE);
  assign ram_re = accept && (in_op == OP_READ);

  tmgr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_frame (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr_r),
    .wr_data (glyph_r[7:0]),
    .rd_en   (ram_re),
    .rd_addr (in_addr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    line_nxt       = line_r;
    col_nxt        = col_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    glyph_nxt      = glyph_r;
    wr_addr_nxt    = wr_addr_r;
    wr_cnt_nxt     = wr_cnt_r;
    hit_nxt        = hit_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_tdata_nxt  = out_tdata_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_data_nxt   = 8'd0;
          res_status_nxt = ST_DONE;
          state_nxt      = S_PEND;
          case (in_op)
            OP_CLEAR: begin
              line_nxt  = 3'd0;
              col_nxt   = 5'd0;
              valid_nxt = '0;
            end
            OP_READ: begin
              hit_nxt   = r_in_text && valid_r[r_idx];
              state_nxt = S_READ;
            end
            OP_PUT: begin
              if (line_r >= LINES_L) begin
                res_status_nxt = ST_DROPPED;
              end else if (in_code == CHAR_NEWLINE) begin
                line_nxt       = line_r + 3'd1;
                col_nxt        = 5'd0;
                res_status_nxt = ST_NEWLINE;
              end else if (p_line >= LINES_L) begin
                // wrapped off the last line: cursor moves, glyph is lost
                line_nxt       = p_line;
                col_nxt        = p_col;
                res_status_nxt = ST_DROPPED;
              end else begin
                line_nxt          = p_line;
                col_nxt           = p_col + 5'd1;
                res_status_nxt    = ST_DRAWN;
                valid_nxt[p_cell] = 1'b1;
                glyph_nxt         = glyph_lookup(in_code);
                wr_addr_nxt       = {p_line[1:0], 8'd0} + {2'b0, p_col6};
                wr_cnt_nxt        = 3'd0;
                state_nxt         = S_WRITE;
              end
            end
            default: ;  // unused opcode: no state change
          endcase
        end
      end
      S_WRITE: begin
        glyph_nxt   = glyph_r >> 8;
        wr_addr_nxt = wr_addr_r + 1'b1;
        wr_cnt_nxt  = wr_cnt_r + 3'd1;
        if (wr_cnt_r == LAST_COL) state_nxt = S_PEND;
      end
      S_READ: begin
        res_data_nxt = hit_r ? ram_rdata : 8'd0;
        state_nxt    = S_PEND;
      end
      S_PEND: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {6'd0, col_r, line_r, res_status_r, res_data_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      line_r      <= 3'd0;
      col_r       <= 5'd0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    glyph_r      <= glyph_nxt;
    wr_addr_r    <= wr_addr_nxt;
    wr_cnt_r     <= wr_cnt_nxt;
    hit_r        <= hit_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  // cursor line never passes the screen-full mark
  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_r <= LINES_L)
    else $error("cursor line beyond screen-full mark");

  // a drawn glyph leaves the cursor past it, on a real line
  a_drawn_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[9:8] == ST_DRAWN)
    |-> (out_tdata[17:13] != 5'd0) && (out_tdata[12:10] < LINES_L))
    else $error("drawn result with inconsistent cursor");

  // glyph write burst stays within one cell
  a_write_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (wr_cnt_r <= LAST_COL) && !in_tready)
    else $error("glyph write burst overran its cell");

  // an accepted read moves to S_READ, where the registered RAM data is loaded
  a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_READ) |=> (state_r == S_READ))
    else $error("read did not wait for the frame store");

endmodule
